// ----- rtl/kds_pkg.sv -----
// kds_pkg: shared types and constants for the keyword decision smoother
// used by the top level and its checker; no dependencies

package kds_pkg;

  localparam int CLASS_W         = 4;
  localparam int COUNT_W         = 4;
  localparam int REG_W           = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int NUM_CLASSES_DEF = 16;
  localparam int TDATA_W         = 8;

  localparam logic [REG_W-1:0] LIMIT_RST  = 4'd15;
  localparam logic [REG_W-1:0] THRESH_RST = 4'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_THRESHOLD = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/kds_ram.sv -----
// kds_ram: generic single-clock RAM, one write port and one registered read port
// no dependencies

module kds_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/keyword_decision_smoother_top.sv -----
// keyword_decision_smoother_top: per-class vote counters in a RAM, frame winner,
// two-frame stability filter and change-of-keyword report; uses kds_pkg, kds_ram

// One transaction in on the slave side carries a classifier decision for one
// frame; exactly one transaction comes out per input, holding a detect flag and
// the detected class (zero when nothing is reported). The vote counters live in
// a small RAM and are swept once per frame, one class per cycle: read, update
// (the chosen class counts up to count_limit, the others count down to zero),
// write back, and track the largest count above win_threshold, lowest index on
// ties. From one acceptance to the next, an item passes through the sweep,
// reading one counter per class, a drain state for the RAM read latency, a
// finish state for the stability filter and the idle state that takes the next
// transaction. The result sits in an output register, so the next frame is
// accepted while it waits; a result still waiting holds the filter cycle of the
// next frame until it is taken. Counters read as zero until first written
// (per-entry valid flags), so no clearing pass is needed after reset. Write
// configuration only while idle.

module keyword_decision_smoother_top import kds_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  // decision stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,   // [3:0] class_index, [7:4] zero
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata    // [0] detected, [4:1] detected_class, [7:5] zero
);

  localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int XW = (AW > CLASS_W) ? AW : CLASS_W;

  // configuration registers
  logic [REG_W-1:0] count_limit;
  logic [REG_W-1:0] win_threshold;

  // control
  state_t state, state_next;
  logic [CLASS_W-1:0] sel;           // class chosen this frame
  logic [AW-1:0]      cnt;           // sweep read address
  logic               rd_valid;      // read data valid for rd_idx
  logic [AW-1:0]      rd_idx;
  logic [NUM_CLASSES-1:0] cnt_valid; // counter written since reset

  // frame winner search
  logic [COUNT_W-1:0] best;
  logic               win_valid;
  logic [AW-1:0]      win_class;

  // stability filter and report state
  logic          cand_valid;
  logic [AW-1:0] cand_class;
  logic          rep_valid;
  logic [AW-1:0] rep_class;

  // output register
  logic               out_valid;
  logic               out_det;
  logic [CLASS_W-1:0] out_class;

  // read-modify-write datapath
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] vote_old;
  logic [COUNT_W-1:0] vote_new;
  logic               hit;

  logic               in_accept;
  logic               last_issue;
  logic               finish_go;
  logic               same_wc;
  logic               same_rep;
  logic               stab_valid;
  logic [AW-1:0]      stab_class;
  logic               det;

  kds_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(NUM_CLASSES)
  ) u_votes (
    .clk  (clk),
    .we   (rd_valid),
    .waddr(rd_idx),
    .wdata(vote_new),
    .raddr(cnt),
    .rdata(ram_rdata)
  );

  // counter update: never-written entries read as zero
  always_comb begin
    vote_old = cnt_valid[rd_idx] ? ram_rdata : '0;
    hit      = (XW'(rd_idx) == XW'(sel));
    if (hit) begin
      vote_new = (vote_old < count_limit) ? vote_old + 1'b1 : vote_old;
    end else begin
      vote_new = (vote_old != '0) ? vote_old - 1'b1 : vote_old;
    end
  end

  // two frames must agree, then report on change of the stable value
  always_comb begin
    same_wc    = (win_valid == cand_valid) && (!win_valid || win_class == cand_class);
    stab_valid = same_wc ? cand_valid : 1'b0;
    stab_class = same_wc ? cand_class : '0;
    same_rep   = (stab_valid == rep_valid) && (!stab_valid || stab_class == rep_class);
    det        = !same_rep && stab_valid;
  end

  assign s_tready   = (state == ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign last_issue = (cnt == AW'(NUM_CLASSES - 1));
  assign finish_go  = (state == ST_FINISH) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit   <= LIMIT_RST;
      win_threshold <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_LIMIT:   count_limit   <= cfg_data;
        REG_WIN_THRESHOLD: win_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      cnt_valid <= '0;
    end else begin
      rd_valid <= (state == ST_SWEEP);
      if (rd_valid) begin
        cnt_valid[rd_idx] <= 1'b1;
      end
    end
  end

  // sweep datapath and winner search, strict compare keeps the lowest index
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (in_accept) begin
      sel       <= s_tdata[CLASS_W-1:0];
      cnt       <= '0;
      best      <= win_threshold;
      win_valid <= 1'b0;
    end else begin
      if (state == ST_SWEEP) begin
        cnt <= cnt + 1'b1;
      end
      if (rd_valid && vote_new > best) begin
        best      <= vote_new;
        win_valid <= 1'b1;
        win_class <= rd_idx;
      end
    end
  end

  // stability and report state
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
      rep_valid  <= 1'b0;
    end else if (finish_go) begin
      if (!same_wc) begin
        cand_valid <= win_valid;
      end
      if (!same_rep) begin
        rep_valid <= stab_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      if (!same_wc) begin
        cand_class <= win_class;
      end
      if (!same_rep) begin
        rep_class <= stab_class;
      end
      out_det   <= det;
      out_class <= det ? CLASS_W'(stab_class) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_W - CLASS_W - 1){1'b0}}, out_class, out_det};

endmodule

// ----- rtl/kds_checker.sv -----
// kds_checker: port-level assertions for the keyword decision smoother
// uses kds_pkg; bound to keyword_decision_smoother_top

module kds_checker import kds_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [REG_W-1:0]     cfg_data,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [TDATA_W-1:0]   s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [TDATA_W-1:0]   m_tdata
);

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // one frame at a time: no acceptance in the cycle after an acceptance
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // class field is zero unless a detection is reported
  a_class_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[4:1] == '0))
    else $error("class nonzero without detection");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind keyword_decision_smoother_top kds_checker u_kds_checker (.*);
